>>> src/hslgg_pkg.sv
// types, constants and helper functions for the hsl gradient generator
`timescale 1ns / 1ps
`default_nettype none

package hslgg_pkg;

    localparam int MAX_KEYS   = 16;
    localparam int MAX_PIXELS = 64;

    localparam int HUE_W  = 17;
    localparam int SL_W   = 16;
    localparam int IDX_W  = 6;
    localparam int KEYS_W = 5;
    localparam int PIX_W  = 7;

    localparam int DATA_W     = 56;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;

    // shared restoring divider: 16 bit magnitude by 7 bit divisor
    localparam int DIV_W     = 16;
    localparam int DIVR_W    = 7;
    localparam int DIV_STEPS = 16;
    localparam int DCNT_W    = 4;

    localparam logic [HUE_W-1:0] HUE_FULL = 17'd92160;
    localparam logic [HUE_W-1:0] HUE_HALF = 17'd46080;

    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_COUNT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SEC,
        ST_DIV_HUE,
        ST_DIV_SAT,
        ST_DIV_LUM,
        ST_SECTION,
        ST_COMMIT,
        ST_FILL
    } t_state;

    function automatic logic [KEYS_W-1:0] eff_keys(input logic [KEYS_W-1:0] cnt);
        logic [KEYS_W-1:0] res;
        if (cnt == '0) begin
            res = KEYS_W'(1);
        end else if (32'(cnt) > 32'(MAX_KEYS)) begin
            res = KEYS_W'(MAX_KEYS);
        end else begin
            res = cnt;
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] eff_pixels(input logic [PIX_W-1:0] cnt);
        logic [PIX_W-1:0] res;
        if (32'(cnt) > 32'(MAX_PIXELS)) begin
            res = PIX_W'(MAX_PIXELS);
        end else begin
            res = cnt;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/hsl_gradient_generator.sv
// hsl gradient generator: key colors in, interpolated per-pixel hsl values out
//
// usage: each request on the slave stream carries one key color of a frame.
// the first key of a frame is held; every later key releases the section from
// the held key up to it, one pixel request on the master stream per pixel, with
// hue going the short way round the wheel. the last key of a frame also fills
// the remaining pixels with its own color, then the frame starts over.
// m_axis_tlast marks the final pixel caused by one key.
// timing: s_axis_tready is high only while idle. a key that releases a section
// of pixels is accepted and then runs through the shared 1 bit per cycle
// divider (section length, then hue, saturation and lightness steps), sends
// its pixels and ends in a commit step; a key whose section is empty goes from
// the section length divide straight to commit, and a first key or a key with
// no pixels left goes from the accept straight to commit. a closing key then
// sends its fill pixels.
// stalls: the output register holds a pixel until m_axis_tready; pixel output
// then waits, and a new key is still taken while the final pixel waits.
// reset: key_count 2, pixel_count 64, held color zero, a new frame begins.
// a configuration write restarts the frame, but a key already being worked on is not stopped.
`timescale 1ns / 1ps
`default_nettype none

module hsl_gradient_generator (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [hslgg_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [hslgg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                  s_axis_tvalid,
    output      logic                                  s_axis_tready,
    // key_hue[16:0], key_sat[32:17], key_lum[48:33], zero pad
    input  wire logic [hslgg_pkg::DATA_W-1:0]          s_axis_tdata,
    output      logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // pixel_hue[16:0], pixel_sat[32:17], pixel_lum[48:33], pixel_index[54:49], zero pad
    output      logic [hslgg_pkg::DATA_W-1:0]          m_axis_tdata,
    output      logic                                  m_axis_tlast
);

    localparam int HUE_W  = hslgg_pkg::HUE_W;
    localparam int SL_W   = hslgg_pkg::SL_W;
    localparam int IDX_W  = hslgg_pkg::IDX_W;
    localparam int KEYS_W = hslgg_pkg::KEYS_W;
    localparam int PIX_W  = hslgg_pkg::PIX_W;
    localparam int DIV_W  = hslgg_pkg::DIV_W;
    localparam int DIVR_W = hslgg_pkg::DIVR_W;
    localparam int DCNT_W = hslgg_pkg::DCNT_W;

    hslgg_pkg::t_state r_state, n_state;

    // configuration and frame state
    logic [KEYS_W-1:0] r_key_count, n_key_count;
    logic [PIX_W-1:0]  r_pixel_count, n_pixel_count;
    logic [KEYS_W-1:0] r_keys_seen, n_keys_seen;
    logic [PIX_W-1:0]  r_pixels_left, n_pixels_left;
    logic [IDX_W-1:0]  r_next_pixel, n_next_pixel;
    logic [HUE_W-1:0]  r_prev_hue, n_prev_hue;
    logic [SL_W-1:0]   r_prev_sat, n_prev_sat;
    logic [SL_W-1:0]   r_prev_lum, n_prev_lum;

    // incoming key
    logic [HUE_W-1:0]  r_key_hue, n_key_hue;
    logic [SL_W-1:0]   r_key_sat, n_key_sat;
    logic [SL_W-1:0]   r_key_lum, n_key_lum;

    // divider
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [DIVR_W-1:0] r_rem, n_rem;
    logic [DIVR_W-1:0] r_divisor, n_divisor;
    logic [DCNT_W-1:0] r_div_cnt, n_div_cnt;

    // section walk
    logic [DIVR_W-1:0]       r_section, n_section;
    logic [DIVR_W-1:0]       r_cnt, n_cnt;
    logic signed [HUE_W-1:0] r_step_h, n_step_h;
    logic signed [SL_W:0]    r_step_s, n_step_s;
    logic signed [SL_W:0]    r_step_l, n_step_l;
    logic [HUE_W-1:0]        r_acc_h, n_acc_h;
    logic [SL_W-1:0]         r_acc_s, n_acc_s;
    logic [SL_W-1:0]         r_acc_l, n_acc_l;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [HUE_W-1:0]  r_out_hue, n_out_hue;
    logic [SL_W-1:0]   r_out_sat, n_out_sat;
    logic [SL_W-1:0]   r_out_lum, n_out_lum;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic              r_out_last, n_out_last;

    logic                    w_accept;
    logic                    w_out_free;
    logic [HUE_W-1:0]        w_in_hue;
    logic [KEYS_W-1:0]       w_keys;
    logic                    w_closing;
    logic [PIX_W-1:0]        w_left_after;
    logic                    w_fill_pending;
    logic                    w_sec_end;
    logic signed [HUE_W:0]   w_dh_raw;
    logic signed [HUE_W:0]   w_dh;
    logic signed [SL_W:0]    w_ds;
    logic signed [SL_W:0]    w_dl;
    logic [HUE_W:0]          w_abs_h;
    logic [SL_W:0]           w_abs_s;
    logic [SL_W:0]           w_abs_l;
    logic [DIVR_W:0]         w_rem_sh;
    logic                    w_ge;
    logic [DIVR_W-1:0]       w_rem_nx;
    logic [DIV_W-1:0]        w_quo_nx;
    logic                    w_div_last;
    logic                    w_q_neg;
    logic [DIV_W:0]          w_q_signed;
    logic signed [HUE_W+1:0] w_hsum;
    logic [HUE_W-1:0]        w_hue_nx;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_in_hue = (s_axis_tdata[HUE_W-1:0] >= hslgg_pkg::HUE_FULL)
                    ? s_axis_tdata[HUE_W-1:0] - hslgg_pkg::HUE_FULL
                    : s_axis_tdata[HUE_W-1:0];

    assign w_keys         = hslgg_pkg::eff_keys(r_key_count);
    assign w_closing      = ({1'b0, r_keys_seen} + (KEYS_W+1)'(1)) >= {1'b0, w_keys};
    assign w_left_after   = r_pixels_left - r_section;
    assign w_fill_pending = w_closing && (w_left_after != '0);
    assign w_sec_end      = (r_cnt == r_section - DIVR_W'(1));

    // color differences, hue the short way round
    always_comb begin
        w_dh_raw = $signed({1'b0, r_key_hue}) - $signed({1'b0, r_prev_hue});
        if (w_dh_raw < -$signed({1'b0, hslgg_pkg::HUE_HALF})) begin
            w_dh = w_dh_raw + $signed({1'b0, hslgg_pkg::HUE_FULL});
        end else if (w_dh_raw > $signed({1'b0, hslgg_pkg::HUE_HALF})) begin
            w_dh = w_dh_raw - $signed({1'b0, hslgg_pkg::HUE_FULL});
        end else begin
            w_dh = w_dh_raw;
        end
    end

    assign w_ds    = $signed({1'b0, r_key_sat}) - $signed({1'b0, r_prev_sat});
    assign w_dl    = $signed({1'b0, r_key_lum}) - $signed({1'b0, r_prev_lum});
    assign w_abs_h = w_dh[HUE_W] ? (HUE_W+1)'(-w_dh) : (HUE_W+1)'(w_dh);
    assign w_abs_s = w_ds[SL_W] ? (SL_W+1)'(-w_ds) : (SL_W+1)'(w_ds);
    assign w_abs_l = w_dl[SL_W] ? (SL_W+1)'(-w_dl) : (SL_W+1)'(w_dl);

    // one restoring divide step per cycle
    assign w_rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign w_ge       = w_rem_sh >= {1'b0, r_divisor};
    assign w_rem_nx   = w_ge ? DIVR_W'(w_rem_sh - {1'b0, r_divisor}) : w_rem_sh[DIVR_W-1:0];
    assign w_quo_nx   = {r_quo[DIV_W-2:0], w_ge};
    assign w_div_last = (r_div_cnt == DCNT_W'(hslgg_pkg::DIV_STEPS - 1));

    always_comb begin
        case (r_state)
            hslgg_pkg::ST_DIV_HUE: w_q_neg = w_dh[HUE_W];
            hslgg_pkg::ST_DIV_SAT: w_q_neg = w_ds[SL_W];
            hslgg_pkg::ST_DIV_LUM: w_q_neg = w_dl[SL_W];
            default:               w_q_neg = 1'b0;
        endcase
    end

    assign w_q_signed = w_q_neg ? (DIV_W+1)'(-{1'b0, w_quo_nx}) : {1'b0, w_quo_nx};

    // hue accumulator wraps modulo 360 degrees
    always_comb begin
        w_hsum = $signed({2'b00, r_acc_h}) + $signed({{2{r_step_h[HUE_W-1]}}, r_step_h});
        if (w_hsum < 0) begin
            w_hue_nx = HUE_W'(w_hsum + $signed({2'b00, hslgg_pkg::HUE_FULL}));
        end else if (w_hsum >= $signed({2'b00, hslgg_pkg::HUE_FULL})) begin
            w_hue_nx = HUE_W'(w_hsum - $signed({2'b00, hslgg_pkg::HUE_FULL}));
        end else begin
            w_hue_nx = w_hsum[HUE_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hslgg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (r_keys_seen != '0 && r_pixels_left != '0) begin
                        n_state = hslgg_pkg::ST_DIV_SEC;
                    end else begin
                        n_state = hslgg_pkg::ST_COMMIT;
                    end
                end
            end
            hslgg_pkg::ST_DIV_SEC: begin
                if (w_div_last) begin
                    n_state = (w_quo_nx != '0) ? hslgg_pkg::ST_DIV_HUE : hslgg_pkg::ST_COMMIT;
                end
            end
            hslgg_pkg::ST_DIV_HUE: begin
                if (w_div_last) n_state = hslgg_pkg::ST_DIV_SAT;
            end
            hslgg_pkg::ST_DIV_SAT: begin
                if (w_div_last) n_state = hslgg_pkg::ST_DIV_LUM;
            end
            hslgg_pkg::ST_DIV_LUM: begin
                if (w_div_last) n_state = hslgg_pkg::ST_SECTION;
            end
            hslgg_pkg::ST_SECTION: begin
                if (w_out_free && w_sec_end) n_state = hslgg_pkg::ST_COMMIT;
            end
            hslgg_pkg::ST_COMMIT: begin
                n_state = w_fill_pending ? hslgg_pkg::ST_FILL : hslgg_pkg::ST_IDLE;
            end
            hslgg_pkg::ST_FILL: begin
                if (w_out_free && r_pixels_left == PIX_W'(1)) n_state = hslgg_pkg::ST_IDLE;
            end
            default: n_state = hslgg_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_key_count   = r_key_count;
        n_pixel_count = r_pixel_count;
        n_keys_seen   = r_keys_seen;
        n_pixels_left = r_pixels_left;
        n_next_pixel  = r_next_pixel;
        n_prev_hue    = r_prev_hue;
        n_prev_sat    = r_prev_sat;
        n_prev_lum    = r_prev_lum;
        n_key_hue     = r_key_hue;
        n_key_sat     = r_key_sat;
        n_key_lum     = r_key_lum;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_divisor     = r_divisor;
        n_div_cnt     = r_div_cnt;
        n_section     = r_section;
        n_cnt         = r_cnt;
        n_step_h      = r_step_h;
        n_step_s      = r_step_s;
        n_step_l      = r_step_l;
        n_acc_h       = r_acc_h;
        n_acc_s       = r_acc_s;
        n_acc_l       = r_acc_l;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_hue     = r_out_hue;
        n_out_sat     = r_out_sat;
        n_out_lum     = r_out_lum;
        n_out_idx     = r_out_idx;
        n_out_last    = r_out_last;

        s_axis_tready = (r_state == hslgg_pkg::ST_IDLE);

        if (i_cfg_wr_en) begin
            n_keys_seen  = '0;
            n_next_pixel = '0;
            case (i_cfg_addr)
                hslgg_pkg::CFG_KEY_COUNT: begin
                    n_key_count   = i_cfg_data[KEYS_W-1:0];
                    n_pixels_left = hslgg_pkg::eff_pixels(r_pixel_count);
                end
                hslgg_pkg::CFG_PIXEL_COUNT: begin
                    n_pixel_count = i_cfg_data[PIX_W-1:0];
                    n_pixels_left = hslgg_pkg::eff_pixels(i_cfg_data[PIX_W-1:0]);
                end
                default: begin
                    n_pixels_left = r_pixels_left;
                end
            endcase
        end

        case (r_state)
            hslgg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_key_hue = w_in_hue;
                    n_key_sat = s_axis_tdata[HUE_W+SL_W-1:HUE_W];
                    n_key_lum = s_axis_tdata[HUE_W+2*SL_W-1:HUE_W+SL_W];
                    n_section = '0;
                    n_quo     = {{(DIV_W-PIX_W){1'b0}}, PIX_W'(r_pixels_left - PIX_W'(1))};
                    n_rem     = '0;
                    n_div_cnt = '0;
                    n_divisor = {{(DIVR_W-KEYS_W){1'b0}}, KEYS_W'(w_keys - r_keys_seen)};
                end
            end
            hslgg_pkg::ST_DIV_SEC, hslgg_pkg::ST_DIV_HUE,
            hslgg_pkg::ST_DIV_SAT, hslgg_pkg::ST_DIV_LUM: begin
                n_quo     = w_quo_nx;
                n_rem     = w_rem_nx;
                n_div_cnt = r_div_cnt + DCNT_W'(1);
                if (w_div_last) begin
                    n_rem     = '0;
                    n_div_cnt = '0;
                    case (r_state)
                        hslgg_pkg::ST_DIV_SEC: begin
                            n_section = w_quo_nx[DIVR_W-1:0];
                            n_divisor = w_quo_nx[DIVR_W-1:0];
                            n_quo     = w_abs_h[DIV_W-1:0];
                        end
                        hslgg_pkg::ST_DIV_HUE: begin
                            n_step_h = $signed(w_q_signed[HUE_W-1:0]);
                            n_quo    = w_abs_s[DIV_W-1:0];
                        end
                        hslgg_pkg::ST_DIV_SAT: begin
                            n_step_s = $signed(w_q_signed);
                            n_quo    = w_abs_l[DIV_W-1:0];
                        end
                        default: begin
                            n_step_l = $signed(w_q_signed);
                            n_acc_h  = r_prev_hue;
                            n_acc_s  = r_prev_sat;
                            n_acc_l  = r_prev_lum;
                            n_cnt    = '0;
                        end
                    endcase
                end
            end
            hslgg_pkg::ST_SECTION: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_hue    = r_acc_h;
                    n_out_sat    = r_acc_s;
                    n_out_lum    = r_acc_l;
                    n_out_idx    = r_next_pixel;
                    n_out_last   = w_sec_end && !w_fill_pending;
                    n_next_pixel = r_next_pixel + IDX_W'(1);
                    n_acc_h      = w_hue_nx;
                    n_acc_s      = r_acc_s + r_step_s[SL_W-1:0];
                    n_acc_l      = r_acc_l + r_step_l[SL_W-1:0];
                    n_cnt        = r_cnt + DIVR_W'(1);
                end
            end
            hslgg_pkg::ST_COMMIT: begin
                n_prev_hue    = r_key_hue;
                n_prev_sat    = r_key_sat;
                n_prev_lum    = r_key_lum;
                n_keys_seen   = r_keys_seen + KEYS_W'(1);
                n_pixels_left = w_left_after;
                if (w_closing && !w_fill_pending) begin
                    n_keys_seen   = '0;
                    n_pixels_left = hslgg_pkg::eff_pixels(r_pixel_count);
                    n_next_pixel  = '0;
                end
            end
            hslgg_pkg::ST_FILL: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_hue     = r_prev_hue;
                    n_out_sat     = r_prev_sat;
                    n_out_lum     = r_prev_lum;
                    n_out_idx     = r_next_pixel;
                    n_out_last    = (r_pixels_left == PIX_W'(1));
                    n_next_pixel  = r_next_pixel + IDX_W'(1);
                    n_pixels_left = r_pixels_left - PIX_W'(1);
                    if (r_pixels_left == PIX_W'(1)) begin
                        n_keys_seen   = '0;
                        n_pixels_left = hslgg_pkg::eff_pixels(r_pixel_count);
                        n_next_pixel  = '0;
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hslgg_pkg::ST_IDLE;
            r_key_count   <= KEYS_W'(2);
            r_pixel_count <= PIX_W'(64);
            r_keys_seen   <= '0;
            r_pixels_left <= hslgg_pkg::eff_pixels(PIX_W'(64));
            r_next_pixel  <= '0;
            r_prev_hue    <= '0;
            r_prev_sat    <= '0;
            r_prev_lum    <= '0;
            r_out_valid   <= 1'b0;
            r_div_cnt     <= '0;
            r_section     <= '0;
            r_cnt         <= '0;
        end else begin
            r_state       <= n_state;
            r_key_count   <= n_key_count;
            r_pixel_count <= n_pixel_count;
            r_keys_seen   <= n_keys_seen;
            r_pixels_left <= n_pixels_left;
            r_next_pixel  <= n_next_pixel;
            r_prev_hue    <= n_prev_hue;
            r_prev_sat    <= n_prev_sat;
            r_prev_lum    <= n_prev_lum;
            r_out_valid   <= n_out_valid;
            r_div_cnt     <= n_div_cnt;
            r_section     <= n_section;
            r_cnt         <= n_cnt;
        end
        r_key_hue  <= n_key_hue;
        r_key_sat  <= n_key_sat;
        r_key_lum  <= n_key_lum;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_divisor  <= n_divisor;
        r_step_h   <= n_step_h;
        r_step_s   <= n_step_s;
        r_step_l   <= n_step_l;
        r_acc_h    <= n_acc_h;
        r_acc_s    <= n_acc_s;
        r_acc_l    <= n_acc_l;
        r_out_hue  <= n_out_hue;
        r_out_sat  <= n_out_sat;
        r_out_lum  <= n_out_lum;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(hslgg_pkg::DATA_W-HUE_W-2*SL_W-IDX_W){1'b0}},
                            r_out_idx, r_out_lum, r_out_sat, r_out_hue};

endmodule

`default_nettype wire

>>> verif/hsl_gradient_generator_tb.sv
// self-checking testbench for the hsl gradient generator: key colors in, predicted pixels checked
`timescale 1ns / 1ps

module hsl_gradient_generator_tb;

    localparam int DATA_W     = hslgg_pkg::DATA_W;
    localparam int HUE_W      = hslgg_pkg::HUE_W;
    localparam int SL_W       = hslgg_pkg::SL_W;
    localparam int IDX_W      = hslgg_pkg::IDX_W;
    localparam int KEYS_W     = hslgg_pkg::KEYS_W;
    localparam int PIX_W      = hslgg_pkg::PIX_W;
    localparam int MAX_KEYS   = hslgg_pkg::MAX_KEYS;
    localparam int MAX_PIXELS = hslgg_pkg::MAX_PIXELS;
    localparam int CFG_ADDR_W = hslgg_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = hslgg_pkg::CFG_DATA_W;

    localparam logic [HUE_W-1:0]      HUE_FULL        = hslgg_pkg::HUE_FULL;
    localparam logic [HUE_W-1:0]      HUE_HALF        = hslgg_pkg::HUE_HALF;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_COUNT   = hslgg_pkg::CFG_KEY_COUNT;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_COUNT = hslgg_pkg::CFG_PIXEL_COUNT;

    localparam int CLK_HALF      = 6;
    localparam int RST_CYCLES    = 7;
    localparam int RANDOM_KEYS   = 460;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int PAD_W         = DATA_W - HUE_W - 2 * SL_W;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [SL_W-1:0]  sat;
        logic [SL_W-1:0]  lum;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_pixel;

    class gradient_scoreboard;
        logic [KEYS_W-1:0] key_count;
        logic [PIX_W-1:0]  pixel_count;
        logic [HUE_W-1:0]  held_hue;
        logic [SL_W-1:0]   held_sat;
        logic [SL_W-1:0]   held_lum;
        int unsigned       keys_seen;
        int unsigned       pixels_left;
        logic [IDX_W-1:0]  next_pixel;
        t_pixel            pixel_q[$];
        int                errors;

        function new();
            key_count   = KEYS_W'(2);
            pixel_count = PIX_W'(64);
            held_hue    = '0;
            held_sat    = '0;
            held_lum    = '0;
            errors      = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            keys_seen   = 0;
            pixels_left = (pixel_count > PIX_W'(MAX_PIXELS)) ? MAX_PIXELS : pixel_count;
            next_pixel  = '0;
        endfunction

        function int unsigned frame_keys();
            if (key_count == '0) begin
                return 1;
            end
            if (key_count > KEYS_W'(MAX_KEYS)) begin
                return MAX_KEYS;
            end
            return key_count;
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function logic [HUE_W-1:0] wrap_hue(longint h);
            longint r;
            r = h % longint'(HUE_FULL);
            if (r < 0) begin
                r += longint'(HUE_FULL);
            end
            return HUE_W'(r);
        endfunction

        function void emit(logic [HUE_W-1:0] hue, logic [SL_W-1:0] sat, logic [SL_W-1:0] lum);
            t_pixel p;
            p.hue  = hue;
            p.sat  = sat;
            p.lum  = lum;
            p.idx  = next_pixel;
            p.last = 1'b0;
            pixel_q.push_back(p);
            next_pixel = next_pixel + 1'b1;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
            if (addr == CFG_KEY_COUNT) begin
                key_count = val[KEYS_W-1:0];
            end else if (addr == CFG_PIXEL_COUNT) begin
                pixel_count = val[PIX_W-1:0];
            end else begin
                return;
            end
            restart_frame();
        endfunction

        function void note_key(logic [HUE_W-1:0] hue_in, logic [SL_W-1:0] sat,
                               logic [SL_W-1:0] lum);
            logic [HUE_W-1:0] hue;
            int unsigned      keys;
            int unsigned      keys_left;
            int unsigned      section;
            int unsigned      k;
            int unsigned      produced;
            longint           dh;
            longint           alt;
            longint           hue_step;
            longint           sat_step;
            longint           lum_step;
            hue      = HUE_W'(longint'(hue_in) % longint'(HUE_FULL));
            keys     = frame_keys();
            produced = 0;
            if (keys_seen > 0) begin
                keys_left = keys - (keys_seen - 1);
                section   = 0;
                if (pixels_left > 0 && keys_left > 1) begin
                    section = (pixels_left - 1) / (keys_left - 1);
                end
                if (section > pixels_left) begin
                    section = pixels_left;
                end
                if (section > 0) begin
                    // shorter way round the wheel, direct difference kept on a tie
                    dh  = longint'(hue) - longint'(held_hue);
                    alt = dh + longint'(HUE_FULL);
                    if (magnitude(alt) < magnitude(dh)) begin
                        dh = alt;
                    end else begin
                        alt = dh - longint'(HUE_FULL);
                        if (magnitude(alt) < magnitude(dh)) begin
                            dh = alt;
                        end
                    end
                    hue_step = dh / longint'(section);
                    sat_step = (longint'(sat) - longint'(held_sat)) / longint'(section);
                    lum_step = (longint'(lum) - longint'(held_lum)) / longint'(section);
                    for (k = 0; k < section; k++) begin
                        emit(wrap_hue(longint'(held_hue) + longint'(k) * hue_step),
                             SL_W'(longint'(held_sat) + longint'(k) * sat_step),
                             SL_W'(longint'(held_lum) + longint'(k) * lum_step));
                    end
                    produced += section;
                    pixels_left -= section;
                end
            end
            held_hue = hue;
            held_sat = sat;
            held_lum = lum;
            keys_seen++;
            if (keys_seen >= keys) begin
                for (k = 0; k < pixels_left; k++) begin
                    emit(hue, sat, lum);
                end
                produced += pixels_left;
                restart_frame();
            end
            if (produced > 0) begin
                pixel_q[pixel_q.size() - 1].last = 1'b1;
            end
        endfunction

        function void mismatch(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_pixel(logic [DATA_W-1:0] data, logic last);
            t_pixel want;
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel, expected none, actual data %h last %b",
                         $time, data, last);
                return;
            end
            want = pixel_q.pop_front();
            if (data[HUE_W-1:0] !== want.hue) begin
                mismatch("pixel_hue", want.hue, data[HUE_W-1:0]);
            end
            if (data[HUE_W +: SL_W] !== want.sat) begin
                mismatch("pixel_sat", want.sat, data[HUE_W +: SL_W]);
            end
            if (data[HUE_W + SL_W +: SL_W] !== want.lum) begin
                mismatch("pixel_lum", want.lum, data[HUE_W + SL_W +: SL_W]);
            end
            if (data[HUE_W + 2 * SL_W +: IDX_W] !== want.idx) begin
                mismatch("pixel_index", want.idx, data[HUE_W + 2 * SL_W +: IDX_W]);
            end
            if (last !== want.last) begin
                mismatch("last", want.last, last);
            end
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;

    gradient_scoreboard    scoreboard = new();
    int                    idle_cycles = 0;
    int                    burst_left = 0;
    int                    keys_sent = 0;
    bit                    hold_pending = 1'b0;
    logic [KEYS_W-1:0]     keys_cfg = KEYS_W'(2);
    logic [HUE_W-1:0]      last_hue = '0;

    hsl_gradient_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                scoreboard.write_reg(i_cfg_addr, i_cfg_data);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                scoreboard.check_pixel(m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                scoreboard.note_key(s_axis_tdata[HUE_W-1:0], s_axis_tdata[HUE_W +: SL_W],
                                    s_axis_tdata[HUE_W + SL_W +: SL_W]);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver backpressure, with one long hold-off on request
    initial begin
        int mode;
        int span;
        int tick;
        m_axis_tready <= 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                tick++;
                if (hold_pending) begin
                    hold_pending = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end else begin
                    case (mode)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= 1'($urandom_range(0, 1));
                        2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                        default: m_axis_tready <= (tick % 5 == 0);
                    endcase
                end
            end
        end
    end

    task automatic send_key(input logic [HUE_W-1:0] hue, input logic [SL_W-1:0] sat,
                            input logic [SL_W-1:0] lum);
        int gap;
        s_axis_tdata  <= {{PAD_W{1'b0}}, lum, sat, hue};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        keys_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // stop offering keys until every pixel is out and the block is idle
    task automatic settle();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
        end
        @(posedge i_clk);
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_addr  <= addr;
        i_cfg_data  <= val;
        i_cfg_wr_en <= 1'b1;
        if (addr == CFG_KEY_COUNT) begin
            keys_cfg = val[KEYS_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SL_W'($urandom);
        endcase
    endfunction

    task automatic rand_key(output logic [HUE_W-1:0] hue, output logic [SL_W-1:0] sat,
                            output logic [SL_W-1:0] lum);
        case ($urandom_range(0, 7))
            0: hue = '0;
            1: hue = HUE_W'(longint'(HUE_FULL) - 1);
            2: hue = HUE_W'($urandom_range(HUE_FULL, (1 << HUE_W) - 1));
            // exactly opposite the previous key
            3: hue = HUE_W'((longint'(last_hue) % longint'(HUE_FULL) + longint'(HUE_HALF))
                            % longint'(HUE_FULL));
            default: hue = HUE_W'($urandom);
        endcase
        last_hue = hue;
        sat = pick_level();
        lum = pick_level();
    endtask

    initial begin
        int                    frame_len;
        int                    n_keys;
        int                    random_start;
        bit                    hold_done;
        logic [CFG_DATA_W-1:0] val;
        logic [HUE_W-1:0]      hue;
        logic [SL_W-1:0]       sat;
        logic [SL_W-1:0]       lum;
        hold_done     = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: full-range extremes, then an exact half turn
        send_key(17'd0, 16'd0, 16'd0);
        send_key(17'h1FFFF, 16'hFFFF, 16'hFFFF);
        send_key(17'd0, 16'hFFFF, 16'd0);
        send_key(HUE_HALF, 16'd0, 16'hFFFF);
        settle();
        // short strip, hue crossing zero both ways
        cfg_write(CFG_PIXEL_COUNT, 7'd4);
        send_key(17'd92000, 16'd100, 16'd200);
        send_key(17'd300, 16'd40000, 16'd30000);
        send_key(17'd300, 16'hFFFF, 16'd1);
        send_key(17'd92100, 16'd2, 16'hFFFE);
        settle();
        // single key frames
        cfg_write(CFG_KEY_COUNT, 7'd1);
        cfg_write(CFG_PIXEL_COUNT, 7'd5);
        send_key(17'd12345, 16'd777, 16'd888);
        send_key(17'd92159, 16'hFFFF, 16'd0);
        settle();
        // zero keys and zero pixels
        cfg_write(CFG_KEY_COUNT, 7'd0);
        cfg_write(CFG_PIXEL_COUNT, 7'd0);
        send_key(17'd5000, 16'd6000, 16'd7000);
        settle();
        // one pixel for four keys, sections all empty
        cfg_write(CFG_KEY_COUNT, 7'd4);
        cfg_write(CFG_PIXEL_COUNT, 7'd1);
        send_key(17'd1000, 16'd10, 16'd20);
        send_key(17'd2000, 16'd30, 16'd40);
        send_key(17'd3000, 16'd50, 16'd60);
        send_key(17'd4000, 16'd70, 16'd80);
        settle();
        // oversized pixel count, frame cut short by a write
        cfg_write(CFG_KEY_COUNT, 7'd3);
        cfg_write(CFG_PIXEL_COUNT, 7'd127);
        send_key(17'd80000, 16'd1, 16'hFFFF);
        send_key(17'd10000, 16'hFFFF, 16'd1);
        settle();
        cfg_write(CFG_KEY_COUNT, 7'd31);

        random_start = keys_sent;
        while (keys_sent - random_start < RANDOM_KEYS) begin
            settle();
            if (!hold_done && keys_sent - random_start >= 150) begin
                cfg_write(CFG_KEY_COUNT, 7'd8);
                cfg_write(CFG_PIXEL_COUNT, 7'd64);
                hold_pending = 1'b1;
                hold_done    = 1'b1;
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0: val = 7'd0;
                        1: val = 7'd1;
                        2: val = 7'd16;
                        3: val = CFG_DATA_W'($urandom_range(17, 127));
                        default: val = CFG_DATA_W'($urandom_range(2, 6));
                    endcase
                    cfg_write(CFG_KEY_COUNT, val);
                end
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0: val = 7'd0;
                        1: val = 7'd64;
                        2: val = CFG_DATA_W'($urandom_range(65, 127));
                        3: val = 7'd1;
                        default: val = CFG_DATA_W'($urandom_range(2, 20));
                    endcase
                    cfg_write(CFG_PIXEL_COUNT, val);
                end
            end
            if (keys_cfg == '0) begin
                frame_len = 1;
            end else if (keys_cfg > KEYS_W'(MAX_KEYS)) begin
                frame_len = MAX_KEYS;
            end else begin
                frame_len = keys_cfg;
            end
            if ($urandom_range(0, 4) == 0) begin
                n_keys = $urandom_range(1, 2 * frame_len);
            end else begin
                n_keys = frame_len * $urandom_range(1, 3);
            end
            repeat (n_keys) begin
                rand_key(hue, sat, lum);
                send_key(hue, sat, lum);
            end
        end
        settle();

        if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
